/* src/date_string_validator_macros.svh */
// ----------------------------------------------------------------------------
// date_string_validator_macros.svh
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef DATE_STRING_VALIDATOR_MACROS_SVH
`define DATE_STRING_VALIDATOR_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DSV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define DSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* src/dsv_pkg.sv */
// ----------------------------------------------------------------------------
// dsv_pkg
// types, codes and constants of the date string validator
// ----------------------------------------------------------------------------
package dsv_pkg;

    // string layout
    localparam int unsigned DATE_LENGTH = 10;
    localparam logic [3:0]  POS_MAX     = 4'd15;
    localparam logic [3:0]  POS_DOT_A   = 4'd2;
    localparam logic [3:0]  POS_DOT_B   = 4'd5;
    localparam logic [3:0]  POS_LAST    = 4'(DATE_LENGTH - 1);
    localparam logic [3:0]  POS_END     = 4'(DATE_LENGTH);

    // character codes
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // value limits
    localparam logic [6:0] MONTH_MAX   = 7'd12;
    localparam logic [6:0] MON_FEB     = 7'd2;
    localparam logic [6:0] MON_APR     = 7'd4;
    localparam logic [6:0] MON_JUN     = 7'd6;
    localparam logic [6:0] MON_SEP     = 7'd9;
    localparam logic [6:0] MON_NOV     = 7'd11;
    localparam logic [6:0] DAYS_LONG   = 7'd31;
    localparam logic [6:0] DAYS_SHORT  = 7'd30;
    localparam logic [6:0] DAYS_FEB_LY = 7'd29;
    localparam logic [6:0] DAYS_FEB    = 7'd28;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_NONDIGIT = 3'd2,
        ST_NODOT    = 3'd3,
        ST_MONTH    = 3'd4,
        ST_DAY      = 3'd5,
        ST_DAYS     = 3'd6
    } t_status;

    // first structure error seen in the string
    typedef enum logic [1:0] {
        SE_NONE     = 2'd0,
        SE_NONDIGIT = 2'd1,
        SE_NODOT    = 2'd2
    } t_serr;

    // one classified string, front to back
    typedef struct packed {
        t_status     status;
        logic        leap;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [13:0] year;
    } t_rec;

    // queue depth
    localparam int unsigned QDEPTH = 2;

endpackage

/* src/dsv_front.sv */
// ----------------------------------------------------------------------------
// dsv_front
// accepts characters, checks structure, builds day, month and year
// ----------------------------------------------------------------------------
module dsv_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_char_code,
    input  logic          i_is_last,
    input  logic          i_q_ready,
    output logic          o_q_push,
    output dsv_pkg::t_rec o_q_rec
);
    import dsv_pkg::*;

    logic [3:0]  r_pos,   n_pos;
    t_serr       r_err,   n_err;
    logic [6:0]  r_day,   n_day;
    logic [6:0]  r_month, n_month;
    logic [13:0] r_year,  n_year;
    logic [3:0]  r_dig [4];
    logic [3:0]  n_dig [4];

    logic        accept;
    logic        is_digit;
    logic [3:0]  dig;
    logic        dot_pos;
    logic [9:0]  day_mul;
    logic [9:0]  month_mul;
    logic [16:0] year_mul;
    logic [4:0]  lo_mod;
    logic [4:0]  hi_mod;
    logic        lo_zero;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && o_ready;

    // character class
    assign is_digit = (i_char_code >= CHAR_ZERO) && (i_char_code <= CHAR_NINE);
    assign dig      = is_digit ? 4'(i_char_code - CHAR_ZERO) : 4'd0;
    assign dot_pos  = (r_pos == POS_DOT_A) || (r_pos == POS_DOT_B);

    // times ten plus digit
    assign day_mul   = {r_day, 3'b000} + {2'b00, r_day, 1'b0} + {6'd0, dig};
    assign month_mul = {r_month, 3'b000} + {2'b00, r_month, 1'b0} + {6'd0, dig};
    assign year_mul  = {r_year, 3'b000} + {2'b00, r_year, 1'b0} + {13'd0, dig};

    // next state of the string being parsed
    always_comb begin
        n_err   = r_err;
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_dig   = r_dig;
        if (r_pos < POS_END) begin
            if (dot_pos) begin
                if ((i_char_code != CHAR_DOT) && (r_err == SE_NONE)) begin
                    n_err = SE_NODOT;
                end
            end else begin
                if (!is_digit && (r_err == SE_NONE)) begin
                    n_err = SE_NONDIGIT;
                end
                if (r_pos < POS_DOT_A) begin
                    n_day = day_mul[6:0];
                end else if (r_pos < POS_DOT_B) begin
                    n_month = month_mul[6:0];
                end else begin
                    n_year   = year_mul[13:0];
                    n_dig[3] = r_dig[2];
                    n_dig[2] = r_dig[1];
                    n_dig[1] = r_dig[0];
                    n_dig[0] = dig;
                end
            end
        end
        n_pos = (r_pos == POS_MAX) ? POS_MAX : r_pos + 4'd1;
    end

    // leap year from the last four year digits: mod 4 of 10a+b is mod 4 of 2a+b
    assign lo_mod  = {n_dig[1], 1'b0} + {1'b0, n_dig[0]};
    assign hi_mod  = {n_dig[3], 1'b0} + {1'b0, n_dig[2]};
    assign lo_zero = (n_dig[1] == 4'd0) && (n_dig[0] == 4'd0);

    // record handed to the back end
    always_comb begin
        o_q_rec.day   = n_day;
        o_q_rec.month = n_month;
        o_q_rec.year  = n_year;
        o_q_rec.leap  = (lo_mod[1:0] == 2'd0) && (!lo_zero || (hi_mod[1:0] == 2'd0));
        if (r_pos != POS_LAST) begin
            o_q_rec.status = ST_LENGTH;
        end else if (n_err == SE_NONDIGIT) begin
            o_q_rec.status = ST_NONDIGIT;
        end else if (n_err == SE_NODOT) begin
            o_q_rec.status = ST_NODOT;
        end else begin
            o_q_rec.status = ST_OK;
        end
    end

    assign o_q_push = accept && i_is_last;

    // parse state, cleared after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_is_last)) begin
            r_pos   <= '0;
            r_err   <= SE_NONE;
            r_day   <= '0;
            r_month <= '0;
            r_year  <= '0;
            for (int k = 0; k < 4; k++) begin
                r_dig[k] <= '0;
            end
        end else if (accept) begin
            r_pos   <= n_pos;
            r_err   <= n_err;
            r_day   <= n_day;
            r_month <= n_month;
            r_year  <= n_year;
            r_dig   <= n_dig;
        end
    end

endmodule

/* src/dsv_fifo.sv */
// ----------------------------------------------------------------------------
// dsv_fifo
// two-entry queue of classified strings between front and back
// ----------------------------------------------------------------------------
module dsv_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dsv_pkg::t_rec i_rec,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output dsv_pkg::t_rec o_rec
);
    import dsv_pkg::*;

    t_rec       r_mem [QDEPTH];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_ready = (r_cnt != 2'(QDEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_rec   = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // pointer and count update
    always_comb begin
        n_wp  = do_push ? ~r_wp : r_wp;
        n_rp  = do_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

endmodule

/* src/dsv_back.sv */
// ----------------------------------------------------------------------------
// dsv_back
// value checks on a classified string and the output register
// ----------------------------------------------------------------------------
module dsv_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  dsv_pkg::t_rec i_q_rec,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [2:0]    o_status,
    output logic [6:0]    o_day_value,
    output logic [6:0]    o_month_value,
    output logic [13:0]   o_year_value
);
    import dsv_pkg::*;

    logic        r_valid;
    logic [2:0]  r_status, n_status;
    logic [6:0]  r_day,    n_day;
    logic [6:0]  r_month,  n_month;
    logic [13:0] r_year,   n_year;
    logic        short_month;
    logic        struct_bad;

    assign o_q_pop = i_q_valid && (!r_valid || i_ready);

    assign short_month = (i_q_rec.month == MON_APR) || (i_q_rec.month == MON_JUN)
                      || (i_q_rec.month == MON_SEP) || (i_q_rec.month == MON_NOV);
    assign struct_bad  = (i_q_rec.status != ST_OK);

    // month, day, short month, february, in that order
    always_comb begin
        t_status st;
        st = i_q_rec.status;
        if (!struct_bad) begin
            if ((i_q_rec.month == 7'd0) || (i_q_rec.month > MONTH_MAX)) begin
                st = ST_MONTH;
            end else if ((i_q_rec.day == 7'd0) || (i_q_rec.day > DAYS_LONG)) begin
                st = ST_DAY;
            end else if (short_month && (i_q_rec.day > DAYS_SHORT)) begin
                st = ST_DAYS;
            end else if ((i_q_rec.month == MON_FEB) && i_q_rec.leap
                         && (i_q_rec.day > DAYS_FEB_LY)) begin
                st = ST_DAYS;
            end else if ((i_q_rec.month == MON_FEB) && !i_q_rec.leap
                         && (i_q_rec.day > DAYS_FEB)) begin
                st = ST_DAYS;
            end
        end
        n_status = st;
        n_day    = struct_bad ? 7'd0  : i_q_rec.day;
        n_month  = struct_bad ? 7'd0  : i_q_rec.month;
        n_year   = struct_bad ? 14'd0 : i_q_rec.year;
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_status <= n_status;
            r_day    <= n_day;
            r_month  <= n_month;
            r_year   <= n_year;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_day_value   = r_day;
    assign o_month_value = r_month;
    assign o_year_value  = r_year;

endmodule

/* src/date_string_validator.sv */
// ----------------------------------------------------------------------------
// date_string_validator
// DD.MM.YYYY date string checker with parsed day, month and year
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready): one character word per cycle, i_is_last
// set on the final character of a string. Output channel (o_valid /
// i_ready): one result word per string, status code plus parsed fields.
// Characters are taken at one per cycle while o_ready is high; strings may follow back to back.
// Result path: the result of a string is written into a queue entry when its
// last character is accepted, then into the output register; words already
// waiting ahead of it in the queue are passed out first.
// Throughput: one character per cycle while o_ready is high, set by the single
// parse stage; a result word can leave every cycle while i_ready is high.
// A two-entry queue sits between the parser and the checker. When the
// receiver stalls, the output register holds its word, the queue fills, and
// o_ready drops only once the queue is full.
// Reset clears the parse state, empties the queue and drops o_valid; a
// partly received string is discarded.
// ----------------------------------------------------------------------------
module date_string_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [6:0]  o_day_value,
    output logic [6:0]  o_month_value,
    output logic [13:0] o_year_value
);
    import dsv_pkg::*;

    logic q_ready;
    logic q_push;
    t_rec q_in;
    logic q_valid;
    logic q_pop;
    t_rec q_out;

    // parser
    dsv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .i_is_last   (i_is_last),
        .i_q_ready   (q_ready),
        .o_q_push    (q_push),
        .o_q_rec     (q_in)
    );

    // queue
    dsv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_out)
    );

    // value checks and output register
    dsv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_rec       (q_out),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_day_value   (o_day_value),
        .o_month_value (o_month_value),
        .o_year_value  (o_year_value)
    );

endmodule

/* src/dsv_checker.sv */
// ----------------------------------------------------------------------------
// dsv_checker
// port-level checks of the date string validator, bound to the top level
// ----------------------------------------------------------------------------
`include "date_string_validator_macros.svh"

module dsv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_char_code,
    input logic        i_is_last,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [6:0]  o_day_value,
    input logic [6:0]  o_month_value,
    input logic [13:0] o_year_value
);
    import dsv_pkg::*;

    // a stalled result word holds
    `DSV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_year_value))

    // no result word right after reset
    `DSV_ASSERT_NEXT(a_rst_idle, i_clk, 1'b1, !i_rst_n, !o_valid)

    // structure failures carry zero fields
    `DSV_ASSERT_IMPLY(a_zero_fields, i_clk, i_rst_n, o_valid && (o_status == ST_LENGTH || o_status == ST_NONDIGIT || o_status == ST_NODOT), o_day_value == 7'd0 && o_month_value == 7'd0 && o_year_value == 14'd0)

    // a good date lies in range
    `DSV_ASSERT_IMPLY(a_ok_range, i_clk, i_rst_n, o_valid && (o_status == ST_OK), o_month_value >= 7'd1 && o_month_value <= MONTH_MAX && o_day_value >= 7'd1 && o_day_value <= DAYS_LONG && o_year_value <= 14'd9999)

    // o_valid rises only after reset has been released
    `DSV_ASSERT_IMPLY(a_cause, i_clk, i_rst_n, $rose(o_valid), $past(i_rst_n, 2))

endmodule

bind date_string_validator dsv_checker u_dsv_checker (.*);
